/* rtl/chgw_pkg.sv */
// Package for the gift-wrap convex hull core: sizes, arithmetic widths,
// the controller state type and the point store write port type.
// Used by every module of the core; depends on nothing.
package chgw_pkg;

   // Store depth and coordinate width.
   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 32;

   // Port width of one coordinate word.
   localparam int WORD_W = 32;

   // Store address, point count and stored entry widths.
   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int ENTRY_W = 2 * COORD_BITS;

   // Coordinate difference, product and squared length widths.
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int LEN_W   = PROD_W;

   // Controller states.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_LM_FETCH,
      ST_LM_CMP,
      ST_WALK_START,
      ST_CHECK,
      ST_FETCH,
      ST_DIFF,
      ST_MUL1,
      ST_MUL2,
      ST_DECIDE,
      ST_EMIT,
      ST_CLOSE
   } state_type;

   // Write port of the point store.
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [ENTRY_W-1:0] data;
   } ram_wr_type;

endpackage

/* rtl/chgw_point_ram.sv */
// Point store of the gift-wrap core: one write port, one registered read port.
// Each entry holds a point as {y, x}. Depends on chgw_pkg.
module chgw_point_ram (
   input  logic                          clock,
   input  chgw_pkg::ram_wr_type          wr,
   input  logic [chgw_pkg::IDX_W-1:0]    rd_addr,
   output logic [chgw_pkg::ENTRY_W-1:0]  rd_data
);

   logic [chgw_pkg::ENTRY_W-1:0] mem [chgw_pkg::MAX_POINTS];
   logic [chgw_pkg::ENTRY_W-1:0] rd_data_ff;

   // Write an entry when the port is enabled.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/convex_hull_gift_wrap_core.sv */
// Top level of the gift-wrap (Jarvis march) convex hull core.
// Holds the controller and the exact cross product and length datapath;
// depends on chgw_pkg and chgw_point_ram.
//
// Usage:
//   Points enter on the req_ ports; a word is taken at a rising edge where
//   start is high and busy is low. Points are stored one per cycle while busy
//   stays low. Points beyond the store depth are dropped and every result of
//   that set carries rsp_overflowed. The word with req_point_last set (stored
//   or dropped) closes the set and raises busy.
//   Hull vertices then leave on the rsp_ ports, each for exactly one cycle
//   with rsp_valid high, followed by the start vertex again with rsp_hull_end
//   set. The receiver cannot stall the block and need not.
//   After the last word the leftmost search reads every stored point once. Each
//   vertex then passes every stored point through one read of the store and the
//   shared two-multiplier orientation unit, and the close follows the last
//   vertex. busy falls in the cycle the closing word is shown.
//   Reset (synchronous, active high) empties the set, clears the overflow
//   flag and returns to taking points; no clearing pass is needed.
module convex_hull_gift_wrap_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [chgw_pkg::WORD_W-1:0] req_point_x,
   input  logic signed [chgw_pkg::WORD_W-1:0] req_point_y,
   input  logic                         req_point_last,
   output logic                         rsp_valid,
   output logic signed [chgw_pkg::WORD_W-1:0] rsp_hull_x,
   output logic signed [chgw_pkg::WORD_W-1:0] rsp_hull_y,
   output logic                         rsp_hull_end,
   output logic                         rsp_overflowed
);

   // Control state.
   chgw_pkg::state_type state_ff, state_in;
   logic [chgw_pkg::CNT_W-1:0] count_ff, count_in;
   logic drop_ff, drop_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Walk state and datapath registers.
   logic [chgw_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [chgw_pkg::CNT_W-1:0] nvert_ff, nvert_in;
   logic first_ff, first_in;
   logic init_ff, init_in;
   logic signed [chgw_pkg::COORD_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [chgw_pkg::COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [chgw_pkg::COORD_BITS-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [chgw_pkg::COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [chgw_pkg::DIFF_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [chgw_pkg::DIFF_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [chgw_pkg::LEN_W-1:0] vlen_ff, vlen_in;
   logic signed [chgw_pkg::PROD_W-1:0] prod0_ff, prod0_in, prod1_ff, prod1_in;
   logic signed [chgw_pkg::CROSS_W-1:0] cross_ff, cross_in;
   logic signed [chgw_pkg::WORD_W-1:0] hx_ff, hx_in, hy_ff, hy_in;
   logic hend_ff, hend_in, hovf_ff, hovf_in;

   // Store ports.
   chgw_pkg::ram_wr_type ram_wr;
   logic [chgw_pkg::IDX_W-1:0] ram_rd_addr;
   logic [chgw_pkg::ENTRY_W-1:0] ram_rd_data;
   logic signed [chgw_pkg::COORD_BITS-1:0] rd_x, rd_y;

   // Datapath helpers.
   logic accept;
   logic last_idx;
   logic lm_take;
   logic walk_go;
   logic signed [chgw_pkg::DIFF_W-1:0] op0a, op0b, op1a, op1b;
   logic signed [chgw_pkg::PROD_W-1:0] mul0, mul1;
   logic [chgw_pkg::LEN_W-1:0] tlen;
   logic t_zero;
   logic take;

   chgw_point_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_x = ram_rd_data[chgw_pkg::COORD_BITS-1:0];
   assign rd_y = ram_rd_data[chgw_pkg::ENTRY_W-1:chgw_pkg::COORD_BITS];

   assign accept = start && (state_ff == chgw_pkg::ST_LOAD);
   assign busy   = (state_ff != chgw_pkg::ST_LOAD);

   // Store write: take the point while there is room.
   always_comb begin
      ram_wr.en   = accept && (count_ff < chgw_pkg::CNT_W'(chgw_pkg::MAX_POINTS));
      ram_wr.addr = count_ff[chgw_pkg::IDX_W-1:0];
      ram_wr.data = {req_point_y[chgw_pkg::COORD_BITS-1:0],
                     req_point_x[chgw_pkg::COORD_BITS-1:0]};
   end

   assign ram_rd_addr = idx_ff;

   // Scan position compared with the last stored point.
   assign last_idx = (chgw_pkg::CNT_W'(idx_ff) == count_ff - chgw_pkg::CNT_W'(1));

   // Leftmost point search, lowest first on a tie.
   assign lm_take = (idx_ff == '0) || (rd_x < sx_ff) || ((rd_x == sx_ff) && (rd_y < sy_ff));

   // The walk goes on until it is back at the start or the vertex cap is hit.
   assign walk_go = (first_ff || (cx_ff != sx_ff) || (cy_ff != sy_ff)) &&
                    ((chgw_pkg::CNT_W'(1) + nvert_ff) < count_ff);

   // Two shared multipliers: cross terms first, then squared lengths.
   always_comb begin
      if (state_ff == chgw_pkg::ST_MUL1) begin
         op0a = vx_ff;
         op0b = ty_ff;
         op1a = vy_ff;
         op1b = tx_ff;
      end else begin
         op0a = tx_ff;
         op0b = tx_ff;
         op1a = ty_ff;
         op1b = ty_ff;
      end
   end

   assign mul0 = chgw_pkg::PROD_W'(op0a) * chgw_pkg::PROD_W'(op0b);
   assign mul1 = chgw_pkg::PROD_W'(op1a) * chgw_pkg::PROD_W'(op1b);

   // Candidate update: turn clockwise, or farther on a collinear tie.
   assign tlen   = chgw_pkg::LEN_W'($unsigned(prod0_ff)) + chgw_pkg::LEN_W'($unsigned(prod1_ff));
   assign t_zero = (tx_ff == '0) && (ty_ff == '0);
   assign take   = init_ff ||
                   (!t_zero && (cross_ff[chgw_pkg::CROSS_W-1] ||
                                ((cross_ff == '0) && (tlen > vlen_ff))));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chgw_pkg::ST_LOAD: begin
            if (accept && req_point_last) begin
               state_in = chgw_pkg::ST_LM_FETCH;
            end
         end
         chgw_pkg::ST_LM_FETCH:   state_in = chgw_pkg::ST_LM_CMP;
         chgw_pkg::ST_LM_CMP: begin
            state_in = last_idx ? chgw_pkg::ST_WALK_START : chgw_pkg::ST_LM_FETCH;
         end
         chgw_pkg::ST_WALK_START: state_in = chgw_pkg::ST_CHECK;
         chgw_pkg::ST_CHECK: begin
            state_in = walk_go ? chgw_pkg::ST_FETCH : chgw_pkg::ST_CLOSE;
         end
         chgw_pkg::ST_FETCH:      state_in = chgw_pkg::ST_DIFF;
         chgw_pkg::ST_DIFF:       state_in = chgw_pkg::ST_MUL1;
         chgw_pkg::ST_MUL1:       state_in = chgw_pkg::ST_MUL2;
         chgw_pkg::ST_MUL2:       state_in = chgw_pkg::ST_DECIDE;
         chgw_pkg::ST_DECIDE: begin
            if (!init_ff && last_idx) begin
               state_in = chgw_pkg::ST_EMIT;
            end else begin
               state_in = chgw_pkg::ST_FETCH;
            end
         end
         chgw_pkg::ST_EMIT:       state_in = chgw_pkg::ST_CHECK;
         chgw_pkg::ST_CLOSE:      state_in = chgw_pkg::ST_LOAD;
         default:                 state_in = chgw_pkg::ST_LOAD;
      endcase
   end

   // Datapath and result register updates.
   always_comb begin
      count_in     = count_ff;
      drop_in      = drop_ff;
      rsp_valid_in = 1'b0;
      idx_in       = idx_ff;
      nvert_in     = nvert_ff;
      first_in     = first_ff;
      init_in      = init_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      vlen_in      = vlen_ff;
      prod0_in     = prod0_ff;
      prod1_in     = prod1_ff;
      cross_in     = cross_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      hend_in      = hend_ff;
      hovf_in      = hovf_ff;
      case (state_ff)
         chgw_pkg::ST_LOAD: begin
            if (accept) begin
               if (ram_wr.en) begin
                  count_in = count_ff + chgw_pkg::CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               idx_in = '0;
            end
         end
         chgw_pkg::ST_LM_FETCH: begin
         end
         chgw_pkg::ST_LM_CMP: begin
            if (lm_take) begin
               sx_in = rd_x;
               sy_in = rd_y;
            end
            idx_in = idx_ff + chgw_pkg::IDX_W'(1);
         end
         chgw_pkg::ST_WALK_START: begin
            cx_in    = sx_ff;
            cy_in    = sy_ff;
            first_in = 1'b1;
            nvert_in = '0;
         end
         chgw_pkg::ST_CHECK: begin
            // First vertex starts from the first stored point, later ones from the last.
            if (walk_go) begin
               idx_in   = first_ff ? '0 : chgw_pkg::IDX_W'(count_ff - chgw_pkg::CNT_W'(1));
               init_in  = 1'b1;
               first_in = 1'b0;
            end
         end
         chgw_pkg::ST_FETCH: begin
         end
         chgw_pkg::ST_DIFF: begin
            px_in = rd_x;
            py_in = rd_y;
            tx_in = chgw_pkg::DIFF_W'(rd_x) - chgw_pkg::DIFF_W'(cx_ff);
            ty_in = chgw_pkg::DIFF_W'(rd_y) - chgw_pkg::DIFF_W'(cy_ff);
         end
         chgw_pkg::ST_MUL1: begin
            prod0_in = mul0;
            prod1_in = mul1;
         end
         chgw_pkg::ST_MUL2: begin
            cross_in = chgw_pkg::CROSS_W'(prod0_ff) - chgw_pkg::CROSS_W'(prod1_ff);
            prod0_in = mul0;
            prod1_in = mul1;
         end
         chgw_pkg::ST_DECIDE: begin
            if (take) begin
               vx_in   = tx_ff;
               vy_in   = ty_ff;
               vlen_in = tlen;
               nx_in   = px_ff;
               ny_in   = py_ff;
            end
            if (init_ff) begin
               init_in = 1'b0;
               idx_in  = '0;
            end else begin
               idx_in = idx_ff + chgw_pkg::IDX_W'(1);
            end
         end
         chgw_pkg::ST_EMIT: begin
            rsp_valid_in = 1'b1;
            hx_in        = chgw_pkg::WORD_W'(cx_ff);
            hy_in        = chgw_pkg::WORD_W'(cy_ff);
            hend_in      = 1'b0;
            hovf_in      = drop_ff;
            nvert_in     = nvert_ff + chgw_pkg::CNT_W'(1);
            cx_in        = nx_ff;
            cy_in        = ny_ff;
         end
         chgw_pkg::ST_CLOSE: begin
            rsp_valid_in = 1'b1;
            hx_in        = chgw_pkg::WORD_W'(sx_ff);
            hy_in        = chgw_pkg::WORD_W'(sy_ff);
            hend_in      = 1'b1;
            hovf_in      = drop_ff;
            count_in     = '0;
            drop_in      = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chgw_pkg::ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      nvert_ff <= nvert_in;
      first_ff <= first_in;
      init_ff  <= init_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      vlen_ff  <= vlen_in;
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
      cross_ff <= cross_in;
      hx_ff    <= hx_in;
      hy_ff    <= hy_in;
      hend_ff  <= hend_in;
      hovf_ff  <= hovf_in;
   end

   // Result word.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hull_x     = hx_ff;
   assign rsp_hull_y     = hy_ff;
   assign rsp_hull_end   = hend_ff;
   assign rsp_overflowed = hovf_ff;

endmodule

/* rtl/chgw_checker.sv */
// Port-level checks for the gift-wrap convex hull core, bound to its top level.
// Depends on chgw_pkg for widths only.
module chgw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic signed [chgw_pkg::WORD_W-1:0]  req_point_x,
   input logic signed [chgw_pkg::WORD_W-1:0]  req_point_y,
   input logic                                req_point_last,
   input logic                                rsp_valid,
   input logic signed [chgw_pkg::WORD_W-1:0]  rsp_hull_x,
   input logic signed [chgw_pkg::WORD_W-1:0]  rsp_hull_y,
   input logic                                rsp_hull_end,
   input logic                                rsp_overflowed
);

   // No result word right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   // A closing point word starts the hull.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_point_last) |=> busy)
      else $error("closing point word did not start the hull");

   // Vertex words come only while the hull is being worked on.
   a_vertex_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hull_end) |-> busy)
      else $error("vertex word outside the hull walk");

   // The closing word ends the walk.
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hull_end) |-> !busy)
      else $error("still busy after the closing word");

   // busy falls only together with the closing word.
   a_fall_end: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_valid && rsp_hull_end))
      else $error("walk ended without a closing word");

endmodule

bind convex_hull_gift_wrap_core chgw_checker u_chgw_checker (.*);
